// File: rtl/tt_pkg.sv
`default_nettype none

package tt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 32;
    localparam int MAX_RESULTS = 16;
    localparam int TIME_W      = 64;
    localparam int ID_PORT_W   = 32;
    localparam int DUR_W       = 32;

    // Request codes
    localparam logic [1:0] REQ_CREATE_ABS = 2'd0;
    localparam logic [1:0] REQ_CREATE_REL = 2'd1;
    localparam logic [1:0] REQ_CANCEL     = 2'd2;
    localparam logic [1:0] REQ_TICK       = 2'd3;

    // Result kinds
    localparam logic [1:0] RES_CREATED  = 2'd0;
    localparam logic [1:0] RES_EXPIRED  = 2'd1;
    localparam logic [1:0] RES_REJECTED = 2'd2;

endpackage

`default_nettype wire

// File: rtl/timeout_table.sv
`default_nettype none

// Channel  | Direction | Handshake         | Payload
// s_       | in        | s_valid / s_ready | req_type, deadline_ns, duration_ns, cancel_id, now_ns
// m_       | out       | m_valid / m_ready | result_kind, entry_id, last, table_empty
//
// A create moves from ST_IDLE to ST_EMIT and loads the result register from there once the
// output register is free. A cancel with a nonzero id walks the id and deadline memory once.
// A tick walks it once to count expired entries and then once more for each expired item
// it emits; the single read port of the memory keeps these walks one after another.
// Reset is synchronous and active low; it clears the valid bits and time and sets the next id to one.
// A waiting result stalls the block only when another result is ready to go out.

module timeout_table
    import tt_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_req_type,
    input  wire logic [TIME_W-1:0]    s_deadline_ns,
    input  wire logic [DUR_W-1:0]     s_duration_ns,
    input  wire logic [ID_PORT_W-1:0] s_cancel_id,
    input  wire logic [TIME_W-1:0]    s_now_ns,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_result_kind,
    output logic [ID_PORT_W-1:0]      m_entry_id,
    output logic                      m_last,
    output logic                      m_table_empty
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EXP_W = $clog2(MAX_RESULTS + 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CANCEL,
        ST_TICK_SCAN,
        ST_TICK_SEL,
        ST_EMIT
    } state_t;

    // Id and deadline memory, one entry per slot
    logic [ID_BITS-1:0] mem_id [SLOTS];
    logic [TIME_W-1:0]  mem_dl [SLOTS];

    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     slot_valid_reg, slot_valid_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic [TIME_W-1:0]    cur_time_reg, cur_time_next;
    logic [ID_PORT_W-1:0] cid_reg, cid_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [ID_BITS-1:0]   rd_id_reg;
    logic [TIME_W-1:0]    rd_dl_reg;
    logic [EXP_W-1:0]     exp_cnt_reg, exp_cnt_next;
    logic [EXP_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic                 any_live_reg, any_live_next;
    logic                 best_found_reg, best_found_next;
    logic [ID_BITS-1:0]   best_id_reg, best_id_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [1:0]           pend_kind_reg, pend_kind_next;
    logic [ID_PORT_W-1:0] pend_id_reg, pend_id_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 pend_empty_reg, pend_empty_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_kind_reg, m_kind_next;
    logic [ID_PORT_W-1:0] m_id_reg, m_id_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_empty_reg, m_empty_next;

    logic                 accept;
    logic                 out_free;
    logic                 scanning;
    logic                 issue;
    logic                 scan_done;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_W:0]      rel_sum;
    logic [TIME_W-1:0]    new_dl;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic                 wr_en;
    logic                 cur_valid;
    logic                 cur_expired;
    logic [EXP_W-1:0]     n_emit;
    logic [ID_BITS-1:0]   id_inc;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_entry_id    = m_id_reg;
    assign m_last        = m_last_reg;
    assign m_table_empty = m_empty_reg;

    assign scanning  = (state_reg == ST_CANCEL) || (state_reg == ST_TICK_SCAN)
                    || (state_reg == ST_TICK_SEL);
    assign issue     = scanning && (scan_cnt_reg < CNT_W'(SLOTS));
    assign scan_done = (scan_cnt_reg == CNT_W'(SLOTS)) && !rd_vld_reg;
    assign rd_addr   = issue ? scan_cnt_reg[IDX_W-1:0] : '0;

    // Relative deadline saturates at all ones.
    assign rel_sum = {1'b0, cur_time_reg} + (TIME_W + 1)'(s_duration_ns);
    assign new_dl  = (s_req_type == REQ_CREATE_ABS) ? s_deadline_ns
                   : (rel_sum[TIME_W] ? '1 : rel_sum[TIME_W-1:0]);

    assign cur_valid   = slot_valid_reg[rd_idx_reg];
    assign cur_expired = cur_valid && (rd_dl_reg <= cur_time_reg);
    assign n_emit      = (exp_cnt_reg > EXP_W'(MAX_RESULTS)) ? EXP_W'(MAX_RESULTS)
                                                             : exp_cnt_reg;
    assign id_inc      = next_id_reg + 1'b1;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign wr_en = accept && free_found
                && ((s_req_type == REQ_CREATE_ABS)
                    || ((s_req_type == REQ_CREATE_REL) && (s_duration_ns != '1)));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_id[free_idx] <= next_id_reg;
            mem_dl[free_idx] <= new_dl;
        end
        rd_id_reg <= mem_id[rd_addr];
        rd_dl_reg <= mem_dl[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        next_id_next    = next_id_reg;
        cur_time_next   = cur_time_reg;
        cid_next        = cid_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        exp_cnt_next    = exp_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        any_live_next   = any_live_reg;
        best_found_next = best_found_reg;
        best_id_next    = best_id_reg;
        best_idx_next   = best_idx_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        pend_last_next  = pend_last_reg;
        pend_empty_next = pend_empty_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;
        m_empty_next    = m_empty_reg;

        if (issue) begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
            rd_vld_next   = 1'b1;
            rd_idx_next   = scan_cnt_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_cnt_next = '0;
                    unique case (s_req_type)
                        REQ_CREATE_ABS, REQ_CREATE_REL: begin
                            pend_last_next = 1'b1;
                            state_next     = ST_EMIT;
                            if ((s_req_type == REQ_CREATE_REL) && (s_duration_ns == '1)) begin
                                pend_kind_next  = RES_CREATED;
                                pend_id_next    = '0;
                                pend_empty_next = ~|slot_valid_reg;
                            end else if (!free_found) begin
                                pend_kind_next  = RES_REJECTED;
                                pend_id_next    = '0;
                                pend_empty_next = 1'b0;
                            end else begin
                                slot_valid_next[free_idx] = 1'b1;
                                pend_kind_next  = RES_CREATED;
                                pend_id_next    = ID_PORT_W'(next_id_reg);
                                pend_empty_next = 1'b0;
                                next_id_next    = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                            end
                        end
                        REQ_CANCEL: begin
                            cid_next = s_cancel_id;
                            if (s_cancel_id != '0) begin
                                state_next = ST_CANCEL;
                            end
                        end
                        REQ_TICK: begin
                            cur_time_next = s_now_ns;
                            exp_cnt_next  = '0;
                            any_live_next = 1'b0;
                            state_next    = ST_TICK_SCAN;
                        end
                    endcase
                end
            end

            ST_CANCEL: begin
                if (rd_vld_reg && cur_valid && (ID_PORT_W'(rd_id_reg) == cid_reg)) begin
                    slot_valid_next[rd_idx_reg] = 1'b0;
                end
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end

            ST_TICK_SCAN: begin
                if (rd_vld_reg) begin
                    if (cur_expired && (exp_cnt_reg != EXP_W'(MAX_RESULTS + 1))) begin
                        exp_cnt_next = exp_cnt_reg + 1'b1;
                    end
                    if (cur_valid && !cur_expired) begin
                        any_live_next = 1'b1;
                    end
                end
                if (scan_done) begin
                    // Entries left pending after this tick keep the table non-empty.
                    pend_empty_next = !any_live_reg
                                   && (exp_cnt_reg <= EXP_W'(MAX_RESULTS));
                    emit_cnt_next   = '0;
                    best_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    state_next      = (exp_cnt_reg == '0) ? ST_IDLE : ST_TICK_SEL;
                end
            end

            ST_TICK_SEL: begin
                // Strict compare keeps the lower slot on equal ids.
                if (rd_vld_reg && cur_expired
                        && (!best_found_reg || (rd_id_reg < best_id_reg))) begin
                    best_found_next = 1'b1;
                    best_id_next    = rd_id_reg;
                    best_idx_next   = rd_idx_reg;
                end
                if (scan_done) begin
                    slot_valid_next[best_idx_reg] = 1'b0;
                    pend_kind_next = RES_EXPIRED;
                    pend_id_next   = ID_PORT_W'(best_id_reg);
                    pend_last_next = ((emit_cnt_reg + 1'b1) == n_emit);
                    emit_cnt_next  = emit_cnt_reg + 1'b1;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = pend_kind_reg;
                    m_id_next       = pend_id_reg;
                    m_last_next     = pend_last_reg;
                    m_empty_next    = pend_empty_reg;
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    state_next      = pend_last_reg ? ST_IDLE : ST_TICK_SEL;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            next_id_reg    <= ID_BITS'(1);
            cur_time_reg   <= '0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            next_id_reg    <= next_id_next;
            cur_time_reg   <= cur_time_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        cid_reg        <= cid_next;
        rd_idx_reg     <= rd_idx_next;
        exp_cnt_reg    <= exp_cnt_next;
        emit_cnt_reg   <= emit_cnt_next;
        any_live_reg   <= any_live_next;
        best_found_reg <= best_found_next;
        best_id_reg    <= best_id_next;
        best_idx_reg   <= best_idx_next;
        pend_kind_reg  <= pend_kind_next;
        pend_id_reg    <= pend_id_next;
        pend_last_reg  <= pend_last_next;
        pend_empty_reg <= pend_empty_next;
        m_kind_reg     <= m_kind_next;
        m_id_reg       <= m_id_next;
        m_last_reg     <= m_last_next;
        m_empty_reg    <= m_empty_next;
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tt_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;

    typedef struct {
        logic [1:0]           kind;
        logic [ID_PORT_W-1:0] id;
        logic                 last;
        logic                 empty;
    } timer_event_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type    = REQ_CREATE_ABS;
    logic [TIME_W-1:0]    s_deadline_ns = '0;
    logic [DUR_W-1:0]     s_duration_ns = '0;
    logic [ID_PORT_W-1:0] s_cancel_id   = '0;
    logic [TIME_W-1:0]    s_now_ns      = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [1:0]           m_result_kind;
    logic [ID_PORT_W-1:0] m_entry_id;
    logic                 m_last;
    logic                 m_table_empty;

    // Timer table mirror, updated when an item is accepted.
    bit                   slot_busy [SLOTS];
    logic [ID_PORT_W-1:0] slot_tag  [SLOTS];
    logic [TIME_W-1:0]    slot_due  [SLOTS];
    logic [ID_PORT_W-1:0] issue_id  = 1;
    logic [TIME_W-1:0]    clock_ns  = '0;

    timer_event_t due_events[$];
    timer_event_t oldest_due;
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    bit           calm           = 1'b0;

    always #1 aclk = ~aclk;

    timeout_table DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_deadline_ns (s_deadline_ns),
        .s_duration_ns (s_duration_ns),
        .s_cancel_id   (s_cancel_id),
        .s_now_ns      (s_now_ns),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_entry_id    (m_entry_id),
        .m_last        (m_last),
        .m_table_empty (m_table_empty)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit table_idle();
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_busy[s]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Lowest free slot takes the deadline; a full table rejects without using an id.
    function automatic timer_event_t book_slot(input logic [TIME_W-1:0] deadline);
        timer_event_t ev;
        ev.last  = 1'b1;
        ev.empty = 1'b0;
        ev.kind  = RES_REJECTED;
        ev.id    = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!slot_busy[s]) begin
                slot_busy[s] = 1'b1;
                slot_tag[s]  = issue_id;
                slot_due[s]  = deadline;
                ev.kind      = RES_CREATED;
                ev.id        = issue_id;
                issue_id     = issue_id + 1;
                if (issue_id == 0) issue_id = 1;
                break;
            end
        end
        return ev;
    endfunction

    task automatic predict_request(input logic [1:0] req, input logic [TIME_W-1:0] deadline,
                                   input logic [DUR_W-1:0] duration,
                                   input logic [ID_PORT_W-1:0] cancel_id,
                                   input logic [TIME_W-1:0] now);
        timer_event_t  batch[$];
        timer_event_t  ev;
        int            best;
        logic [TIME_W:0] sum;
        bit            empty;
        case (req)
            REQ_CREATE_ABS: begin
                batch.push_back(book_slot(deadline));
            end
            REQ_CREATE_REL: begin
                if (duration == {DUR_W{1'b1}}) begin
                    ev.kind = RES_CREATED;
                    ev.id   = '0;
                    ev.last = 1'b1;
                    batch.push_back(ev);
                end else begin
                    sum = {1'b0, clock_ns} + duration;
                    batch.push_back(book_slot(sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0]));
                end
            end
            REQ_CANCEL: begin
                if (cancel_id != 0) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (slot_busy[s] && slot_tag[s] == cancel_id) slot_busy[s] = 1'b0;
                    end
                end
            end
            default: begin
                clock_ns = now;
                while (batch.size() < MAX_RESULTS) begin
                    best = -1;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (slot_busy[s] && slot_due[s] <= now &&
                            (best < 0 || slot_tag[s] < slot_tag[best])) best = s;
                    end
                    if (best < 0) break;
                    ev.kind = RES_EXPIRED;
                    ev.id   = slot_tag[best];
                    ev.last = 1'b0;
                    batch.push_back(ev);
                    slot_busy[best] = 1'b0;
                end
                if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            end
        endcase
        empty = table_idle();
        foreach (batch[k]) begin
            batch[k].empty = empty;
            due_events.push_back(batch[k]);
        end
    endtask

    // Leaves valid high after acceptance so that back-to-back items are offered without a gap.
    task automatic send_item(input logic [1:0] req, input logic [TIME_W-1:0] deadline,
                             input logic [DUR_W-1:0] duration,
                             input logic [ID_PORT_W-1:0] cancel_id,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_deadline_ns <= deadline;
        s_duration_ns <= duration;
        s_cancel_id   <= cancel_id;
        s_now_ns      <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(req, deadline, duration, cancel_id, now);
    endtask

    // A cancel gives no result, so the block may still be busy once the queue is empty.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_events.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_special_values();
        send_item(REQ_CREATE_ABS, '0, $urandom, $urandom, rand64());
        send_item(REQ_CREATE_ABS, {TIME_W{1'b1}}, $urandom, $urandom, rand64());
        send_item(REQ_CREATE_REL, rand64(), '0, $urandom, rand64());
        send_item(REQ_CREATE_REL, rand64(), {DUR_W{1'b1}}, $urandom, rand64());
        send_item(REQ_CREATE_REL, rand64(), 32'hFFFF_FFFE, $urandom, rand64());
        send_item(REQ_CANCEL, rand64(), $urandom, '0, rand64());
        send_item(REQ_CANCEL, rand64(), $urandom, {ID_PORT_W{1'b1}}, rand64());
        send_item(REQ_CANCEL, rand64(), $urandom, 4, rand64());
        send_item(REQ_TICK, rand64(), $urandom, $urandom, '0);
        send_item(REQ_TICK, rand64(), $urandom, $urandom, '0);
        send_item(REQ_TICK, rand64(), $urandom, $urandom, 64'hFFFF_FFFF_FFFF_FFF0);
        // Near the top of the time range a relative create saturates.
        send_item(REQ_CREATE_REL, rand64(), 32'h0000_0100, $urandom, rand64());
        send_item(REQ_CREATE_ABS, 64'h8000_0000_0000_0000, $urandom, $urandom, rand64());
        send_item(REQ_TICK, rand64(), $urandom, $urandom, {TIME_W{1'b1}});
        send_item(REQ_TICK, rand64(), $urandom, $urandom, 64'd5);
        send_item(REQ_CREATE_REL, rand64(), 32'd10, $urandom, rand64());
        send_item(REQ_TICK, rand64(), $urandom, $urandom, 64'd15);
    endtask

    task automatic test_full_table();
        wait_drain();
        for (int i = 0; i < SLOTS; i++) begin
            send_item(REQ_CREATE_ABS, clock_ns + $urandom_range(0, 100), $urandom, $urandom,
                      rand64());
        end
        send_item(REQ_CREATE_ABS, rand64(), $urandom, $urandom, rand64());
        send_item(REQ_CREATE_REL, rand64(), $urandom_range(0, 1000), $urandom, rand64());
        send_item(REQ_CREATE_REL, rand64(), {DUR_W{1'b1}}, $urandom, rand64());
        wait_drain();
        send_item(REQ_TICK, rand64(), $urandom, $urandom, {TIME_W{1'b1}});
        send_item(REQ_TICK, rand64(), $urandom, $urandom, rand64());
    endtask

    task automatic test_random_traffic(input int count);
        int                   pick;
        int                   slot;
        logic [TIME_W-1:0]    deadline;
        logic [DUR_W-1:0]     duration;
        logic [ID_PORT_W-1:0] cancel_id;
        logic [TIME_W-1:0]    now;
        for (int i = 0; i < count; i++) begin
            calm = (i >= 120 && i < 180);
            if (i == 200) wait_drain();
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                deadline = ($urandom_range(0, 9) == 0) ? rand64()
                                                       : clock_ns + $urandom_range(0, 3000);
                send_item(REQ_CREATE_ABS, deadline, $urandom, $urandom, rand64());
            end else if (pick < 55) begin
                case ($urandom_range(0, 19))
                    0:       duration = {DUR_W{1'b1}};
                    1:       duration = $urandom;
                    default: duration = $urandom_range(0, 3000);
                endcase
                send_item(REQ_CREATE_REL, rand64(), duration, $urandom, rand64());
            end else if (pick < 70) begin
                slot = $urandom_range(0, SLOTS - 1);
                case ($urandom_range(0, 4))
                    0:       cancel_id = $urandom;
                    1:       cancel_id = issue_id - $urandom_range(0, 5);
                    default: cancel_id = slot_busy[slot] ? slot_tag[slot] : $urandom;
                endcase
                send_item(REQ_CANCEL, rand64(), $urandom, cancel_id, rand64());
            end else begin
                case ($urandom_range(0, 19))
                    0, 1:    now = rand64();
                    2:       now = clock_ns - $urandom_range(0, 500);
                    default: now = clock_ns + $urandom_range(0, 2000);
                endcase
                send_item(REQ_TICK, rand64(), $urandom, $urandom, now);
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result: kind %0d id %0d last %0b empty %0b",
                             m_result_kind, m_entry_id, m_last, m_table_empty);
            end else begin
                oldest_due = due_events.pop_front();
                if (m_result_kind !== oldest_due.kind || m_entry_id !== oldest_due.id ||
                    m_last !== oldest_due.last || m_table_empty !== oldest_due.empty) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Mismatch: expected kind %0d id %0d last %0b empty %0b, %s",
                                 oldest_due.kind, oldest_due.id, oldest_due.last,
                                 oldest_due.empty,
                                 $sformatf("got kind %0d id %0d last %0b empty %0b",
                                           m_result_kind, m_entry_id, m_last,
                                           m_table_empty));
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_special_values();
        test_full_table();
        test_random_traffic(232);
        wait_drain();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: timeout_table.f
rtl/tt_pkg.sv
rtl/timeout_table.sv
verif/testbench.sv
